// File: rtl/conv3x3_image_filter_core_assert.svh
// assertion macros shared by the conv3x3 image filter checker
`ifndef CONV3X3_IMAGE_FILTER_CORE_ASSERT_SVH
`define CONV3X3_IMAGE_FILTER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define CIF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("conv3x3 image filter check failed");

// next-cycle implication, sampled on clock, off during reset
`define CIF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("conv3x3 image filter check failed");

`endif

// File: rtl/cif_pkg.sv
// types, constants and helpers of the conv3x3 image filter
`default_nettype none

package cif_pkg;

   localparam int KSIZE       = 3;
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 1024;
   localparam int COEF_BITS   = 16;
   localparam int KROW_W      = 48;
   localparam int LW_W        = 9;
   localparam int FH_W        = 11;
   localparam int PIX_W       = 8;
   localparam int RAW_W       = 28;
   localparam int CLIP_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int QUEUE_DEPTH = 2;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int COL_CMP_W = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
   localparam int ROW_CMP_W = (ROW_W + 1 > FH_W) ? ROW_W + 1 : FH_W;
   localparam int PROD_W    = PIX_W + 1 + COEF_BITS;
   localparam int SUM_W     = PROD_W + 4;

   localparam logic [LW_W-1:0] LINE_WIDTH_RESET   = LW_W'(202);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(202);

   // sums at or below this truncate to a negative pixel
   localparam logic signed [SUM_W-1:0] SUM_LOW_CLIP  = SUM_W'(-256);
   // sums at or above this truncate past 255
   localparam logic signed [SUM_W-1:0] SUM_HIGH_CLIP = SUM_W'(256 * 256);

   localparam logic [CLIP_W-1:0] CLIP_NONE = 2'd0;
   localparam logic [CLIP_W-1:0] CLIP_LOW  = 2'd1;
   localparam logic [CLIP_W-1:0] CLIP_HIGH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_ROW_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_ROW_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_ROW_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

   typedef logic [KSIZE-1:0][KROW_W-1:0] kernel_type;

   // tap[j][i]: window column j (oldest first), row i (top first)
   typedef struct packed {
      logic                                  last;
      logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] tap;
   } win_item_type;

   // signed coefficient of column col out of one kernel row register
   function automatic logic signed [COEF_BITS-1:0] coef_at(
      input logic [KROW_W-1:0] row,
      input int unsigned       col
   );
      logic [KSIZE*COEF_BITS+KROW_W-1:0] ext;
      ext = {{(KSIZE*COEF_BITS){1'b0}}, row};
      return ext[col*COEF_BITS +: COEF_BITS];
   endfunction

endpackage

`default_nettype wire

// File: rtl/cif_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module cif_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/cif_front.sv
// front end: pixel intake, row/column tracking, line buffers and window
`default_nettype none

module cif_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [cif_pkg::PIX_W-1:0]    req_pixel_in,
   input  logic                         req_start_of_frame,
   input  logic [cif_pkg::LW_W-1:0]     line_width,
   input  logic [cif_pkg::FH_W-1:0]     frame_height,
   output logic                         push_valid,
   input  logic                         push_ready,
   output cif_pkg::win_item_type        push_item
);

   import cif_pkg::*;

   logic                 acc;
   logic [COL_CMP_W-1:0] lw_ext, w_eff, col_next;
   logic [ROW_CMP_W-1:0] fh_ext, h_eff, row_next;
   logic [COL_W-1:0]     c_cur;
   logic [ROW_W-1:0]     r_cur;
   logic                 col_wrap, row_wrap;

   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]     s1_px_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic                 s1_produce_ff, s1_last_ff;
   logic                 s1_go;

   logic                 byp_ff, byp_in;
   logic [PIX_W-1:0]     byp_a_ff, byp_b_ff;
   logic [PIX_W-1:0]     ram_a_rd, ram_b_rd, col_a, col_b;

   logic [KSIZE-1:0][PIX_W-1:0] win_old_ff, win_mid_ff;

   // effective frame size, clamped
   always_comb begin
      lw_ext = COL_CMP_W'(line_width);
      if (lw_ext < COL_CMP_W'(KSIZE)) begin
         w_eff = COL_CMP_W'(KSIZE);
      end else if (lw_ext > COL_CMP_W'(MAX_WIDTH)) begin
         w_eff = COL_CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = lw_ext;
      end
      fh_ext = ROW_CMP_W'(frame_height);
      if (fh_ext < ROW_CMP_W'(KSIZE)) begin
         h_eff = ROW_CMP_W'(KSIZE);
      end else if (fh_ext > ROW_CMP_W'(MAX_HEIGHT)) begin
         h_eff = ROW_CMP_W'(MAX_HEIGHT);
      end else begin
         h_eff = fh_ext;
      end
   end

   // stage 1 retires when it needs no queue slot or one is free
   assign s1_go     = s1_valid_ff && (!s1_produce_ff || push_ready);
   assign req_stall = s1_valid_ff && !s1_go;
   assign acc       = req_valid && !req_stall;

   assign c_cur    = req_start_of_frame ? '0 : col_ff;
   assign r_cur    = req_start_of_frame ? '0 : row_ff;
   assign col_next = COL_CMP_W'(c_cur) + COL_CMP_W'(1);
   assign row_next = ROW_CMP_W'(r_cur) + ROW_CMP_W'(1);
   assign col_wrap = col_next >= w_eff;
   assign row_wrap = row_next >= h_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : ROW_W'(row_next);
         end else begin
            col_in = COL_W'(col_next);
            row_in = r_cur;
         end
      end
   end

   assign s1_valid_in = acc || (s1_valid_ff && !s1_go);

   // line store write of stage 1 races the next read at the same column
   assign byp_in = s1_go && (s1_col_ff == c_cur);

   assign col_a = byp_ff ? byp_a_ff : ram_a_rd;
   assign col_b = byp_ff ? byp_b_ff : ram_b_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_old_ff  <= '0;
         win_mid_ff  <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            win_old_ff <= win_mid_ff;
            win_mid_ff <= {s1_px_ff, col_a, col_b};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_px_ff      <= req_pixel_in;
         s1_col_ff     <= c_cur;
         s1_produce_ff <= (r_cur >= ROW_W'(KSIZE - 1)) && (c_cur >= COL_W'(KSIZE - 1));
         s1_last_ff    <= row_wrap && col_wrap;
         byp_ff        <= byp_in;
         byp_a_ff      <= s1_px_ff;
         byp_b_ff      <= col_a;
      end
   end

   cif_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (acc),
      .rd_addr (c_cur),
      .rd_data (ram_a_rd)
   );

   cif_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (col_a),
      .rd_en   (acc),
      .rd_addr (c_cur),
      .rd_data (ram_b_rd)
   );

   assign push_valid = s1_go && s1_produce_ff;

   always_comb begin
      push_item.last   = s1_last_ff;
      push_item.tap[0] = win_old_ff;
      push_item.tap[1] = win_mid_ff;
      push_item.tap[2] = {s1_px_ff, col_a, col_b};
   end

endmodule

`default_nettype wire

// File: rtl/cif_queue.sv
// short queue of complete windows between front and back end
`default_nettype none

module cif_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  cif_pkg::win_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop,
   output cif_pkg::win_item_type pop_item
);

   import cif_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   win_item_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign pop_valid  = count_ff != '0;
   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH)) || pop;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cif_back.sv
// back end: multiply, add tree, truncate and saturate, result register
`default_nettype none

module cif_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_pop,
   input  cif_pkg::win_item_type           q_item,
   input  cif_pkg::kernel_type             kernel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cif_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic signed [cif_pkg::RAW_W-1:0] rsp_raw_sum,
   output logic [cif_pkg::CLIP_W-1:0]      rsp_clip_status,
   output logic                            rsp_last_of_frame
);

   import cif_pkg::*;

   logic adv;

   logic                     p_valid_ff, p_last_ff;
   logic signed [PROD_W-1:0] prod_ff [KSIZE][KSIZE];
   logic signed [PROD_W-1:0] prod_in [KSIZE][KSIZE];

   logic                     r_valid_ff, r_last_ff;
   logic signed [SUM_W-1:0]  rsum_ff [KSIZE];
   logic signed [SUM_W-1:0]  rsum_in [KSIZE];

   logic                     s_valid_ff, s_last_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   logic                     out_valid_ff, out_last_ff;
   logic [PIX_W-1:0]         out_pix_ff, out_pix_in;
   logic signed [RAW_W-1:0]  out_raw_ff;
   logic [CLIP_W-1:0]        out_clip_ff, out_clip_in;

   // whole pipeline moves together unless the result is held
   assign adv   = !out_valid_ff || !rsp_stall;
   assign q_pop = adv;

   always_comb begin
      for (int i = 0; i < KSIZE; i++) begin
         for (int j = 0; j < KSIZE; j++) begin
            prod_in[j][i] = PROD_W'($signed({1'b0, q_item.tap[j][i]}))
                          * PROD_W'(coef_at(kernel[i], j));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KSIZE; i++) begin
         rsum_in[i] = '0;
         for (int j = 0; j < KSIZE; j++) begin
            rsum_in[i] = rsum_in[i] + SUM_W'(prod_ff[j][i]);
         end
      end
      sum_in = '0;
      for (int i = 0; i < KSIZE; i++) begin
         sum_in = sum_in + rsum_ff[i];
      end
   end

   // divide by 256 toward zero, then clamp to a pixel
   always_comb begin
      if (sum_ff <= SUM_LOW_CLIP) begin
         out_pix_in  = '0;
         out_clip_in = CLIP_LOW;
      end else if (sum_ff >= SUM_HIGH_CLIP) begin
         out_pix_in  = '1;
         out_clip_in = CLIP_HIGH;
      end else if (sum_ff[SUM_W-1]) begin
         out_pix_in  = '0;
         out_clip_in = CLIP_NONE;
      end else begin
         out_pix_in  = sum_ff[PIX_W+7:8];
         out_clip_in = CLIP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         r_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff   <= q_valid;
         r_valid_ff   <= p_valid_ff;
         s_valid_ff   <= r_valid_ff;
         out_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_last_ff   <= q_item.last;
         prod_ff     <= prod_in;
         r_last_ff   <= p_last_ff;
         rsum_ff     <= rsum_in;
         s_last_ff   <= r_last_ff;
         sum_ff      <= sum_in;
         out_last_ff <= s_last_ff;
         out_pix_ff  <= out_pix_in;
         out_raw_ff  <= RAW_W'(sum_ff);
         out_clip_ff <= out_clip_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_out     = out_pix_ff;
   assign rsp_raw_sum       = out_raw_ff;
   assign rsp_clip_status   = out_clip_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule

`default_nettype wire

// File: rtl/conv3x3_image_filter_core.sv
// top level of the 3x3 image filter: config registers, front, queue, back
//
// streams 8-bit gray pixels of a frame that already carries its one-pixel
// zero border, in raster order, and returns the valid 3x3 correlation with a
// signed Q8.8 kernel: one result per pixel at row and column 2 or more of the
// current frame. each result carries the raw sum in signed Q20.8, the sum
// divided by 256 toward zero and clamped to 0..255, a clip code and a
// last-of-frame mark. sustained rate is one pixel per clock while nothing
// stalls, set by the two line-buffer rams, each read once per accepted pixel
// at its column and written back as it leaves stage 1. a result leaves after
// stage 1, the queue and four back end stages (multiply, row sums, total,
// clamp/result register). kernel rows, line width and frame height must be
// written through the csr port only while no transaction is in flight; the
// block does not enforce this. line width is clamped to 3..256, frame height
// to 3..1024, and the counters wrap at the frame end even without a start mark
`default_nettype none

module conv3x3_image_filter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // pixel input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cif_pkg::PIX_W-1:0]            req_pixel_in,
   input  logic                                 req_start_of_frame,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cif_pkg::PIX_W-1:0]            rsp_pixel_out,
   output logic signed [cif_pkg::RAW_W-1:0]     rsp_raw_sum,
   output logic [cif_pkg::CLIP_W-1:0]           rsp_clip_status,
   output logic                                 rsp_last_of_frame,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cif_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cif_pkg::CSR_DATA_W-1:0]       csr_data
);

   import cif_pkg::*;

   kernel_type      kernel_ff;
   logic [LW_W-1:0] line_width_ff;
   logic [FH_W-1:0] frame_height_ff;

   logic            push_valid, push_ready, pop_valid, pop;
   win_item_type    push_item, pop_item;

   // writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff       <= '0;
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_KERNEL_ROW_0: kernel_ff[0]    <= csr_data[KROW_W-1:0];
            REG_KERNEL_ROW_1: kernel_ff[1]    <= csr_data[KROW_W-1:0];
            REG_KERNEL_ROW_2: kernel_ff[2]    <= csr_data[KROW_W-1:0];
            REG_LINE_WIDTH:   line_width_ff   <= csr_data[LW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[FH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: counters, line buffers and window; retires pixels in order
   cif_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel_in       (req_pixel_in),
      .req_start_of_frame (req_start_of_frame),
      .line_width         (line_width_ff),
      .frame_height       (frame_height_ff),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_item          (push_item)
   );

   // decouples a stalled result channel from pixel intake
   cif_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   // back: nine multiplies, add tree, truncation and saturation
   cif_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (pop_valid),
      .q_pop             (pop),
      .q_item            (pop_item),
      .kernel            (kernel_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_raw_sum       (rsp_raw_sum),
      .rsp_clip_status   (rsp_clip_status),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

`default_nettype wire

// File: rtl/cif_checker.sv
// port-level checker for the 3x3 image filter, bound to the top level
`default_nettype none

`include "conv3x3_image_filter_core_assert.svh"

module cif_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [cif_pkg::PIX_W-1:0]        rsp_pixel_out,
   input logic signed [cif_pkg::RAW_W-1:0] rsp_raw_sum,
   input logic [cif_pkg::CLIP_W-1:0]       rsp_clip_status
);

   import cif_pkg::*;

   // a held result keeps its pixel and sum
   `CIF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_raw_sum) && $stable(rsp_pixel_out))

   // clipping high always gives full white
   `CIF_ASSERT_SAME(a_clip_high, rsp_valid && rsp_clip_status == CLIP_HIGH, rsp_pixel_out == '1 && !rsp_raw_sum[RAW_W-1])

   // clipping low only comes from a negative sum and gives black
   `CIF_ASSERT_SAME(a_clip_low, rsp_valid && rsp_clip_status == CLIP_LOW, rsp_pixel_out == '0 && rsp_raw_sum[RAW_W-1])

   // in range, the pixel is the integer part of the sum
   `CIF_ASSERT_SAME(a_in_range, rsp_valid && rsp_clip_status == CLIP_NONE, rsp_raw_sum[RAW_W-1] ? rsp_pixel_out == '0 : rsp_pixel_out == rsp_raw_sum[PIX_W+7:8])

endmodule

bind conv3x3_image_filter_core cif_checker u_cif_checker (.*);

`default_nettype wire
